// ----- hw/rtl/fixed_block_free_list_allocator_assert.svh -----
// Assertion macros shared by the allocator RTL.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FBFLA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication, disabled during reset.
`define FBFLA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

// ----- hw/rtl/fbfla_pkg.sv -----
// Package for the fixed block free-list allocator: widths, codes, types
// and config helper functions. No dependencies.
package fbfla_pkg;

    localparam int MAX_BLOCKS  = 1024;
    localparam int WORD_BYTES  = 8;
    localparam int HDR_WORDS   = 3;
    localparam int BYTES_LIMIT = 4096;
    localparam int NB_RESET    = 1024;
    localparam int BB_RESET    = 8;

    localparam int IDX_W    = $clog2(MAX_BLOCKS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int NB_W     = 11;
    localparam int CFG_W    = 13;
    localparam int STRIDE_W = 13;
    localparam int OFF_W    = 23;
    localparam int WB_SHIFT = $clog2(WORD_BYTES);
    localparam int OFF_BASE = HDR_WORDS * WORD_BYTES + WORD_BYTES;

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [STRIDE_W-1:0] stride_t;
    typedef logic [OFF_W-1:0]    off_t;
    typedef logic [CFG_W-1:0]    cfg_data_t;

    typedef enum logic
    {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic
    {
        REG_NUM_BLOCKS  = 1'b0,
        REG_BLOCK_BYTES = 1'b1
    } cfg_reg_t;

    typedef enum logic
    {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic latch;   // take the input item, start the link read
        logic exec;    // commit the command and load the result
    } ctl_cmd_t;

    localparam stride_t STRIDE_RESET =
        STRIDE_W'(((BB_RESET + WORD_BYTES - 1) / WORD_BYTES + 1) * WORD_BYTES);

    // Clamp the block count into 1..MAX_BLOCKS.
    function automatic cnt_t eff_blocks(input logic [NB_W-1:0] nb);
        cnt_t n;
        if (nb == '0)
        begin
            n = CNT_W'(1);
        end
        else if (nb > NB_W'(MAX_BLOCKS))
        begin
            n = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            n = CNT_W'(nb);
        end
        return n;
    endfunction

    // Block stride in bytes: payload rounded up to whole words plus one link word.
    function automatic stride_t stride_of(input cfg_data_t bb);
        cfg_data_t b;
        cfg_data_t words;
        if (bb == '0)
        begin
            b = CFG_W'(1);
        end
        else if (bb > CFG_W'(BYTES_LIMIT))
        begin
            b = CFG_W'(BYTES_LIMIT);
        end
        else
        begin
            b = bb;
        end
        words = (b + CFG_W'(WORD_BYTES - 1)) >> WB_SHIFT;
        return STRIDE_W'((words + CFG_W'(1)) << WB_SHIFT);
    endfunction

endpackage

// ----- hw/rtl/fbfla_if.sv -----
// Valid/ready channel interfaces for allocator commands and results.
// Depends on fbfla_pkg.
interface fbfla_req_if;
    import fbfla_pkg::*;

    logic valid;
    logic ready;
    logic cmd;
    idx_t block_index;

    modport source (output valid, output cmd, output block_index, input ready);
    modport sink   (input valid, input cmd, input block_index, output ready);
endinterface

interface fbfla_rsp_if;
    import fbfla_pkg::*;

    logic            valid;
    logic            ready;
    logic [1:0]      status;
    idx_t            granted_index;
    off_t            payload_offset;
    cnt_t            free_count;

    modport source (output valid, output status, output granted_index,
                    output payload_offset, output free_count, input ready);
    modport sink   (input valid, input status, input granted_index,
                    input payload_offset, input free_count, output ready);
endinterface

// ----- hw/rtl/fbfla_ctl.sv -----
// Allocator controller: two-state sequencer and result valid flag.
// Depends on fbfla_pkg and the assertion header.
`include "fixed_block_free_list_allocator_assert.svh"

module fbfla_ctl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output fbfla_pkg::ctl_cmd_t dp_cmd
);
    import fbfla_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        slot_free    = !out_valid_reg || out_ready;
        state_next   = state_reg;
        in_ready     = 1'b0;
        dp_cmd.latch = 1'b0;
        dp_cmd.exec  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                dp_cmd.latch = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold until the result register can take the result
                dp_cmd.exec = slot_free;
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (dp_cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    `FBFLA_ASSERT_NXT(a_exec_loads_result, dp_cmd.exec, out_valid_reg)
    `FBFLA_ASSERT_IMP(a_no_take_in_flight, state_reg == S_EXEC, !in_ready)
    `FBFLA_ASSERT_IMP(a_result_from_exec, $rose(out_valid_reg), $past(state_reg == S_EXEC))

endmodule

// ----- hw/rtl/fbfla_dp.sv -----
// Allocator datapath: free-list state, link memory, offset multiply,
// result registers. Depends on fbfla_pkg and the assertion header.
`include "fixed_block_free_list_allocator_assert.svh"

module fbfla_dp
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  fbfla_pkg::ctl_cmd_t   dp_cmd,
    input  logic                  cfg_we,
    input  fbfla_pkg::cfg_reg_t   cfg_index,
    input  fbfla_pkg::cfg_data_t  cfg_wdata,
    input  logic                  in_cmd,
    input  fbfla_pkg::idx_t       in_block_index,
    output fbfla_pkg::status_t    status,
    output fbfla_pkg::idx_t       granted_index,
    output fbfla_pkg::off_t       payload_offset,
    output fbfla_pkg::cnt_t       free_count
);
    import fbfla_pkg::*;

    idx_t    link_mem [MAX_BLOCKS];
    idx_t    link_rd_reg;

    cmd_t    cmd_reg;
    idx_t    idx_reg;

    cnt_t    neff_reg;
    cnt_t    neff_next;
    stride_t stride_reg;
    stride_t stride_next;
    idx_t    top_reg;
    idx_t    top_next;
    logic    nonempty_reg;
    logic    nonempty_next;
    cnt_t    fresh_reg;
    cnt_t    fresh_next;
    cnt_t    free_reg;
    cnt_t    free_next;

    status_t status_reg;
    idx_t    granted_reg;
    off_t    offset_reg;
    cnt_t    count_reg;

    cnt_t    unissued;
    cnt_t    depth;
    logic    fresh_avail;
    logic    push_we;
    logic    grant;
    idx_t    granted;
    status_t st;
    off_t    product;

    // Link memory: read at the stack top when an item is taken, write on push.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.latch)
        begin
            link_rd_reg <= link_mem[top_reg];
            cmd_reg     <= cmd_t'(in_cmd);
            idx_reg     <= in_block_index;
        end
        if (push_we)
        begin
            link_mem[idx_reg] <= top_reg;
        end
    end

    always_comb
    begin
        unissued    = (fresh_reg < neff_reg) ? (neff_reg - fresh_reg) : '0;
        depth       = (free_reg > unissued) ? (free_reg - unissued) : '0;
        fresh_avail = fresh_reg < neff_reg;

        top_next      = top_reg;
        nonempty_next = nonempty_reg;
        fresh_next    = fresh_reg;
        free_next     = free_reg;
        neff_next     = neff_reg;
        stride_next   = stride_reg;
        push_we       = 1'b0;
        grant         = 1'b0;
        granted       = '0;
        st            = ST_OK;

        if (cmd_reg == CMD_ALLOC)
        begin
            if (nonempty_reg)
            begin
                grant     = 1'b1;
                granted   = top_reg;
                top_next  = link_rd_reg;
                if (depth <= CNT_W'(1))
                begin
                    nonempty_next = 1'b0;
                end
            end
            else if (fresh_avail)
            begin
                grant      = 1'b1;
                granted    = fresh_reg[IDX_W-1:0];
                fresh_next = fresh_reg + CNT_W'(1);
            end
            else
            begin
                st = ST_EMPTY;
            end
            if (grant && (free_reg != '0))
            begin
                free_next = free_reg - CNT_W'(1);
            end
        end
        else
        begin
            if (CNT_W'(idx_reg) >= neff_reg)
            begin
                st = ST_RANGE;
            end
            else
            begin
                push_we       = dp_cmd.exec;
                top_next      = idx_reg;
                nonempty_next = 1'b1;
                if (free_reg < neff_reg)
                begin
                    free_next = free_reg + CNT_W'(1);
                end
            end
        end

        product = OFF_W'(granted) * OFF_W'(stride_reg);

        // drop the command path; a config write reinitializes the pool
        if (!dp_cmd.exec)
        begin
            top_next      = top_reg;
            nonempty_next = nonempty_reg;
            fresh_next    = fresh_reg;
            free_next     = free_reg;
        end
        if (cfg_we)
        begin
            if (cfg_index == REG_NUM_BLOCKS)
            begin
                neff_next = eff_blocks(cfg_wdata[NB_W-1:0]);
            end
            else
            begin
                stride_next = stride_of(cfg_wdata);
            end
            top_next      = '0;
            nonempty_next = 1'b0;
            fresh_next    = '0;
            free_next     = neff_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neff_reg     <= CNT_W'(NB_RESET);
            stride_reg   <= STRIDE_RESET;
            top_reg      <= '0;
            nonempty_reg <= 1'b0;
            fresh_reg    <= '0;
            free_reg     <= CNT_W'(NB_RESET);
        end
        else
        begin
            neff_reg     <= neff_next;
            stride_reg   <= stride_next;
            top_reg      <= top_next;
            nonempty_reg <= nonempty_next;
            fresh_reg    <= fresh_next;
            free_reg     <= free_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (dp_cmd.exec)
        begin
            status_reg  <= st;
            granted_reg <= granted;
            offset_reg  <= grant ? (product + OFF_W'(OFF_BASE)) : '0;
            count_reg   <= free_next;
        end
    end

    assign status         = status_reg;
    assign granted_index  = granted_reg;
    assign payload_offset = offset_reg;
    assign free_count     = count_reg;

    `FBFLA_ASSERT_IMP(a_free_bounded, 1'b1, free_reg <= neff_reg)
    `FBFLA_ASSERT_IMP(a_fresh_bounded, 1'b1, fresh_reg <= neff_reg)
    `FBFLA_ASSERT_IMP(a_list_has_free, nonempty_reg, free_reg != '0)

endmodule

// ----- hw/rtl/fixed_block_free_list_allocator.sv -----
// Fixed block pool allocator, top level. An item is taken in the idle state
// and its result is registered on commit in the exec state, which waits
// while the result register is full. A new item is not taken until the
// last one is committed, as the link memory read at the stack top must come
// ahead of the list head update. Reset clears the list state and restores 1024
// blocks of 8 bytes; the link memory is not cleared and needs no clearing pass.
module fixed_block_free_list_allocator
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  fbfla_pkg::cfg_reg_t  cfg_index,
    input  fbfla_pkg::cfg_data_t cfg_wdata,
    fbfla_req_if.sink            req,
    fbfla_rsp_if.source          rsp
);
    import fbfla_pkg::*;

    ctl_cmd_t dp_cmd;
    logic     in_ready;
    logic     out_valid;
    status_t  status;

    // Sequencer: takes an item in idle, commits it once the result slot is free.
    fbfla_ctl u_ctl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .dp_cmd    (dp_cmd)
    );

    // Datapath: list head, fresh counter, free count, link memory and
    // payload offset multiply; config writes reinitialize the pool here.
    fbfla_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .dp_cmd         (dp_cmd),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_cmd         (req.cmd),
        .in_block_index (req.block_index),
        .status         (status),
        .granted_index  (rsp.granted_index),
        .payload_offset (rsp.payload_offset),
        .free_count     (rsp.free_count)
    );

    assign req.ready  = in_ready;
    assign rsp.valid  = out_valid;
    assign rsp.status = status;

endmodule
